@@ rtl/smhm_pkg.sv @@
// Shared constants, types and helpers for the sliding minimum Hamming matcher.
// No dependencies; every other file in rtl imports this package.
`timescale 1ns / 1ps

package smhm_pkg;

   // Sizing of the window and the position counter
   localparam int MAX_PATTERN   = 32;
   localparam int POSITION_BITS = 24;
   localparam int IDX_BITS      = $clog2(MAX_PATTERN);
   localparam int COUNT_BITS    = $clog2(MAX_PATTERN + 1);

   // Fixed field widths
   localparam int BASE_BITS     = 3;
   localparam int LEN_BITS      = 6;
   localparam int START_BITS    = 24;
   localparam int MIN_BITS      = 6;
   localparam int PATTERN_BITS  = 64;

   // Mismatch count tree: groups of cells summed in the first level
   localparam int GROUP_SIZE    = 4;
   localparam int GROUPS        = MAX_PATTERN / GROUP_SIZE;
   localparam int GROUP_BITS    = $clog2(GROUP_SIZE + 1);

   // Register file: 64-bit data, one register every 8 bytes
   localparam int CSR_DATA_BITS = 64;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_SEL_BITS  = 2;

   localparam logic [CSR_SEL_BITS-1:0] REG_PATTERN  = 2'd0;
   localparam logic [CSR_SEL_BITS-1:0] REG_LENGTH   = 2'd1;
   localparam logic [CSR_SEL_BITS-1:0] REG_DISTANCE = 2'd2;

   localparam logic [LEN_BITS-1:0]     LENGTH_RESET   = 6'd20;
   localparam logic [LEN_BITS-1:0]     DISTANCE_RESET = 6'd5;

   // Base code for any character outside A, C, G, T
   localparam logic [BASE_BITS-1:0]    CODE_OTHER = 3'd4;

   // Configuration as seen by the datapath
   typedef struct packed {
      logic [PATTERN_BITS-1:0] pattern_bases;
      logic [LEN_BITS-1:0]     pattern_length;
      logic [LEN_BITS-1:0]     report_distance;
      logic                    length_write;
      logic [LEN_BITS-1:0]     length_value;
   } cfg_type;

   // Per-cell control from the top level
   typedef struct packed {
      logic       shift;
      logic       active;
      logic [1:0] pat_base;
   } cell_ctrl_type;

   // Clamp the programmed length into 1..MAX_PATTERN
   function automatic logic [LEN_BITS-1:0] eff_len(input logic [LEN_BITS-1:0] len);
      logic [LEN_BITS-1:0] res;
      res = len;
      if (len == '0) begin
         res = LEN_BITS'(1);
      end else if (int'(len) > MAX_PATTERN) begin
         res = LEN_BITS'(MAX_PATTERN);
      end
      return res;
   endfunction

endpackage

@@ rtl/sliding_min_hamming_matcher.sv @@
// Top level of the sliding minimum Hamming matcher: cell row, count tree, result stage.
// Depends on smhm_pkg, smhm_cell and smhm_csr.
`timescale 1ns / 1ps

// The block takes one base per beat and can accept a new base in every cycle
// that req_stall is low; a result passes the cell row, the group-sum stage and
// the output register to reach the rsp_ side. The window is a row of 32 cells that
// shift by one place on each accepted beat and flag their own mismatch against
// the aligned pattern base; the flags are then summed by a two-level registered
// adder tree, and the last stage keeps the running minimum and the exact-match
// flag. A base that gives no result (no report, not the last base) leaves no
// beat on the rsp_ side. The output register lets bases keep flowing while a
// result waits; req_stall rises only when the pipeline is full behind a stalled
// result. Registers should be written only while no base is in flight.
module sliding_min_hamming_matcher (
   input  logic                                clock,
   input  logic                                reset,
   // Input channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [smhm_pkg::BASE_BITS-1:0]      req_base_code,
   input  logic                                req_seq_end,
   // Result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_report_valid,
   output logic [smhm_pkg::START_BITS-1:0]     rsp_window_start,
   output logic                                rsp_final_valid,
   output logic [smhm_pkg::MIN_BITS-1:0]       rsp_min_mismatch,
   // Configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [smhm_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [smhm_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [smhm_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready
);
   import smhm_pkg::*;

   cfg_type                 cfg;
   logic [LEN_BITS-1:0]     len_eff;
   logic                    accept;
   logic [BASE_BITS-1:0]    code;

   // Front: sequence position and fill level
   logic [COUNT_BITS-1:0]   fill_ff, fill_in, fill_next;
   logic [POSITION_BITS-1:0] pos_ff, pos_in, start_now;

   // Cell row
   logic [BASE_BITS-1:0]    chain [MAX_PATTERN];
   logic [MAX_PATTERN-1:0]  miss_vec;

   // Stage 1 control (mismatch flags live in the cells)
   logic                    s1_valid_ff, s1_valid_in;
   logic                    s1_elig_ff, s1_last_ff;
   logic [POSITION_BITS-1:0] s1_start_ff;

   // Stage 2: group sums
   logic                    s2_valid_ff, s2_valid_in;
   logic                    s2_elig_ff, s2_last_ff;
   logic [POSITION_BITS-1:0] s2_start_ff;
   logic [GROUP_BITS-1:0]   s2_sum_ff [GROUPS];
   logic [GROUP_BITS-1:0]   s2_sum_in [GROUPS];

   // Result stage state
   logic [COUNT_BITS-1:0]   best_ff, best_in, best_cand, total;
   logic                    exact_ff, exact_in;
   logic                    examine, report, has_result;
   logic [POSITION_BITS+START_BITS-1:0] start_wide;

   // Output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_report_ff, rsp_final_ff;
   logic [START_BITS-1:0]   rsp_start_ff;
   logic [MIN_BITS-1:0]     rsp_min_ff;

   // Flow control
   logic                    out_ready, s2_leave, s2_ready, s1_ready, s1_move;

   smhm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign len_eff = eff_len(cfg.pattern_length);

   // Handshakes along the pipe
   assign out_ready  = !rsp_valid_ff || !rsp_stall;
   assign s2_leave   = s2_valid_ff && (!has_result || out_ready);
   assign s2_ready   = !s2_valid_ff || s2_leave;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign s1_move    = s1_valid_ff && s2_ready;
   assign req_stall  = !s1_ready;
   assign accept     = req_valid && s1_ready;

   // Fold unused codes onto the "other" code
   assign code = (req_base_code > CODE_OTHER) ? CODE_OTHER : req_base_code;

   // Track fill level and position; restart both after the last base
   always_comb begin
      fill_next = (int'(fill_ff) == MAX_PATTERN) ? fill_ff : fill_ff + COUNT_BITS'(1);
      start_now = pos_ff - POSITION_BITS'(len_eff) + POSITION_BITS'(1);
      fill_in   = fill_ff;
      pos_in    = pos_ff;
      if (accept) begin
         fill_in = req_seq_end ? '0 : fill_next;
         pos_in  = req_seq_end ? '0 : pos_ff + POSITION_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         pos_ff  <= '0;
      end else begin
         fill_ff <= fill_in;
         pos_ff  <= pos_in;
      end
   end

   // Row of cells: cell k holds the base k places back from the newest
   for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
      cell_ctrl_type           ctrl;
      logic [BASE_BITS-1:0]    base_in;
      logic [LEN_BITS-1:0]     pat_idx;

      assign pat_idx       = len_eff - LEN_BITS'(k + 1);
      assign ctrl.shift    = accept;
      assign ctrl.active   = LEN_BITS'(k) < len_eff;
      assign ctrl.pat_base = cfg.pattern_bases[{pat_idx[IDX_BITS-1:0], 1'b0} +: 2];

      if (k == 0) begin : g_head
         assign base_in = code;
      end else begin : g_body
         assign base_in = chain[k-1];
      end

      smhm_cell u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .base_in  (base_in),
         .base_out (chain[k]),
         .miss     (miss_vec[k])
      );
   end

   // Stage 1 control travels with the cell flags
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s2_ready) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_elig_ff  <= fill_next >= COUNT_BITS'(len_eff);
         s1_last_ff  <= req_seq_end;
         s1_start_ff <= start_now;
      end
   end

   // First adder level: count flags in each group
   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         s2_sum_in[g] = '0;
         for (int b = 0; b < GROUP_SIZE; b++) begin
            s2_sum_in[g] = s2_sum_in[g] + GROUP_BITS'(miss_vec[g*GROUP_SIZE + b]);
         end
      end
   end

   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (s1_move) begin
         s2_valid_in = 1'b1;
      end else if (s2_leave) begin
         s2_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_sum_ff   <= s2_sum_in;
         s2_elig_ff  <= s1_elig_ff;
         s2_last_ff  <= s1_last_ff;
         s2_start_ff <= s1_start_ff;
      end
   end

   // Second adder level, then minimum, report check and exact-match flag
   always_comb begin
      total = '0;
      for (int g = 0; g < GROUPS; g++) begin
         total = total + COUNT_BITS'(s2_sum_ff[g]);
      end
      examine    = s2_elig_ff && !exact_ff;
      report     = examine && (LEN_BITS'(total) == cfg.report_distance);
      best_cand  = (examine && (total < best_ff)) ? total : best_ff;
      has_result = report || s2_last_ff;
      start_wide = {{START_BITS{1'b0}}, s2_start_ff};
   end

   always_comb begin
      best_in  = best_ff;
      exact_in = exact_ff;
      if (cfg.length_write) begin
         best_in = COUNT_BITS'(eff_len(cfg.length_value));
      end else if (s2_leave) begin
         if (s2_last_ff) begin
            best_in  = COUNT_BITS'(len_eff);
            exact_in = 1'b0;
         end else begin
            best_in  = best_cand;
            exact_in = exact_ff || (examine && (best_cand == '0));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff  <= COUNT_BITS'(LENGTH_RESET);
         exact_ff <= 1'b0;
      end else begin
         best_ff  <= best_in;
         exact_ff <= exact_in;
      end
   end

   // Output register: load a result beat, drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s2_leave && has_result) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_leave && has_result) begin
         rsp_report_ff <= report;
         rsp_start_ff  <= report ? start_wide[START_BITS-1:0] : '0;
         rsp_final_ff  <= s2_last_ff;
         rsp_min_ff    <= s2_last_ff ? MIN_BITS'(best_cand) : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_report_valid = rsp_report_ff;
   assign rsp_window_start = rsp_start_ff;
   assign rsp_final_valid  = rsp_final_ff;
   assign rsp_min_mismatch = rsp_min_ff;

endmodule

@@ rtl/smhm_cell.sv @@
// One window cell: holds one base of the sliding window and its mismatch flag.
// Depends on smhm_pkg.
`timescale 1ns / 1ps

module smhm_cell (
   input  logic                              clock,
   input  smhm_pkg::cell_ctrl_type           ctrl,
   input  logic [smhm_pkg::BASE_BITS-1:0]    base_in,
   output logic [smhm_pkg::BASE_BITS-1:0]    base_out,
   output logic                              miss
);
   import smhm_pkg::*;

   logic [BASE_BITS-1:0] base_ff;
   logic                 miss_ff;
   logic                 miss_in;

   // Compare the base arriving this beat against the aligned pattern base
   assign miss_in = ctrl.active && (base_in != {1'b0, ctrl.pat_base});

   // Advance the window by one place on every accepted beat
   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         base_ff <= base_in;
         miss_ff <= miss_in;
      end
   end

   assign base_out = base_ff;
   assign miss     = miss_ff;

endmodule

@@ rtl/smhm_csr.sv @@
// Configuration register file behind a simple APB-style port.
// Depends on smhm_pkg.
`timescale 1ns / 1ps

module smhm_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [smhm_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [smhm_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [smhm_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready,
   output smhm_pkg::cfg_type                   cfg
);
   import smhm_pkg::*;

   logic [PATTERN_BITS-1:0] pattern_ff;
   logic [LEN_BITS-1:0]     length_ff;
   logic [LEN_BITS-1:0]     distance_ff;
   logic                    wr;
   logic [CSR_SEL_BITS-1:0] sel;

   assign csr_pready = 1'b1;
   assign wr  = csr_psel && csr_penable && csr_pwrite;
   assign sel = csr_paddr[CSR_ADDR_BITS-1:3];

   // Write the selected register in the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff  <= '0;
         length_ff   <= LENGTH_RESET;
         distance_ff <= DISTANCE_RESET;
      end else if (wr) begin
         unique case (sel)
            REG_PATTERN:  pattern_ff  <= csr_pwdata[PATTERN_BITS-1:0];
            REG_LENGTH:   length_ff   <= csr_pwdata[LEN_BITS-1:0];
            REG_DISTANCE: distance_ff <= csr_pwdata[LEN_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Read back the selected register
   always_comb begin
      unique case (sel)
         REG_PATTERN:  csr_prdata = CSR_DATA_BITS'(pattern_ff);
         REG_LENGTH:   csr_prdata = CSR_DATA_BITS'(length_ff);
         REG_DISTANCE: csr_prdata = CSR_DATA_BITS'(distance_ff);
         default:      csr_prdata = '0;
      endcase
   end

   assign cfg.pattern_bases   = pattern_ff;
   assign cfg.pattern_length  = length_ff;
   assign cfg.report_distance = distance_ff;
   assign cfg.length_write    = wr && (sel == REG_LENGTH);
   assign cfg.length_value    = csr_pwdata[LEN_BITS-1:0];

endmodule

@@ rtl/smhm_checker.sv @@
// Port-level checks for the sliding minimum Hamming matcher, bound to the top level.
// Depends on smhm_pkg and sliding_min_hamming_matcher.
`timescale 1ns / 1ps

module smhm_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic                             rsp_report_valid,
   input  logic [smhm_pkg::START_BITS-1:0]  rsp_window_start,
   input  logic                             rsp_final_valid,
   input  logic [smhm_pkg::MIN_BITS-1:0]    rsp_min_mismatch
);
   import smhm_pkg::*;

   // No result beat straight out of reset
   a_reset_quiet : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat right after reset");

   // Every result beat is a report, a final minimum, or both
   a_beat_has_cause : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_report_valid || rsp_final_valid))
      else $error("result beat with neither report nor final");

   // Start position is zero when no report is carried
   a_start_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_report_valid) |-> (rsp_window_start == '0))
      else $error("window start set without a report");

   // Minimum never exceeds the window size, and is zero off the last base
   a_min_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_final_valid && (int'(rsp_min_mismatch) <= MAX_PATTERN))
                     || (!rsp_final_valid && (rsp_min_mismatch == '0))))
      else $error("minimum mismatch out of range");

   // Hold a stalled beat
   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_report_valid)
         && $stable(rsp_window_start) && $stable(rsp_final_valid)
         && $stable(rsp_min_mismatch)))
      else $error("stalled result beat changed");

endmodule

bind sliding_min_hamming_matcher smhm_checker u_smhm_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_report_valid (rsp_report_valid),
   .rsp_window_start (rsp_window_start),
   .rsp_final_valid  (rsp_final_valid),
   .rsp_min_mismatch (rsp_min_mismatch)
);
